// File: hw/rtl/rdar_pkg.sv
// shared types and constants of the reliable datagram ack/retry engine
package rdar_pkg;

	localparam int DEF_RETRY_DEPTH = 16;
	localparam int DEF_SEEN_DEPTH  = 64;

	localparam logic [15:0] RETRY_INTERVAL_RST = 16'd200;
	localparam logic [31:0] FIRST_ID           = 32'd1;

	// action codes
	localparam logic [2:0] ACT_SEND = 3'd0;
	localparam logic [2:0] ACT_ACK  = 3'd1;
	localparam logic [2:0] ACT_RECV = 3'd2;
	localparam logic [2:0] ACT_DISC = 3'd3;
	localparam logic [2:0] ACT_TICK = 3'd4;
	localparam logic [2:0] ACT_LINK = 3'd5;

	// result kinds
	localparam logic [2:0] KIND_TX      = 3'd0;
	localparam logic [2:0] KIND_RETX    = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_DELIVER = 3'd3;
	localparam logic [2:0] KIND_FULL    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACK_SCAN,
		ST_SHIFT,
		ST_RETX,
		ST_SEEN,
		ST_ACK_EMIT
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [7:0]  handle;
	} pend_entry_t;

	typedef struct packed {
		logic lookup;
		logic record;
	} seen_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} seen_rsp_t;

endpackage

// File: hw/rtl/rdar_seen.sv
// duplicate-suppression ring of received ids with a one-entry-per-cycle lookup
module rdar_seen #(
	parameter int SEEN_DEPTH = rdar_pkg::DEF_SEEN_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rdar_pkg::seen_req_t req,
	input  logic [31:0]        id,
	output rdar_pkg::seen_rsp_t rsp
);
	import rdar_pkg::*;

	localparam int SW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SEEN_DEPTH - 1);

	logic [31:0]           mem [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0] valid_q;
	logic [SW-1:0]         next_q;
	logic [SW-1:0]         sidx_q;
	logic [SW-1:0]         raddr;
	logic                  scan_q;
	logic [31:0]           rd_q;
	logic                  hit;
	logic                  at_end;

	// read address runs one ahead of the compare index
	assign raddr  = (req.lookup || sidx_q == LAST_SLOT) ? '0 : sidx_q + SW'(1);
	assign hit    = scan_q && valid_q[sidx_q] && (rd_q == id);
	assign at_end = (sidx_q == LAST_SLOT);

	always_comb begin
		rsp.done = scan_q && (hit || at_end);
		rsp.hit  = hit;
	end

	always_ff @(posedge clk) begin
		if (req.record) begin
			mem[next_q] <= id;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= 1'b0;
			sidx_q  <= '0;
			valid_q <= '0;
			next_q  <= '0;
		end else begin
			if (req.lookup) begin
				scan_q <= 1'b1;
				sidx_q <= '0;
			end else if (scan_q) begin
				if (hit || at_end) begin
					scan_q <= 1'b0;
				end else begin
					sidx_q <= sidx_q + SW'(1);
				end
			end
			if (req.record) begin
				valid_q[next_q] <= 1'b1;
				next_q <= (next_q == LAST_SLOT) ? '0 : next_q + SW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/reliable_datagram_ack_retry.sv
// top level of the reliable datagram engine: sequencer, retry table, timer and config
//
// channel   direction  handshake                      word
// command   in         start && !busy                 action, msg_id, payload_handle, elapsed
// result    out        strobe (one cycle, no stall)   kind, out_id, out_handle, last
// config    in/out     apb: psel, penable, pwrite     retry_interval at byte address 0
//
// send, link up and plain ticks finish in the decode state
// ack: scan the table entry by entry up to the matching id, then shift the later entries down one by one
// receive/disconnect: walk the duplicate-store slots (up to SEEN_DEPTH) until a hit or the last slot
// tick with retransmit: one result per outstanding entry, one result per cycle
// the single table read port and the single id comparator of each store set this pace
// reset clears table count, timer, link flag and seen valid bits and sets the id counter to FIRST_ID at once
// the receiver cannot stall: each result word is on the ports for exactly one cycle
module reliable_datagram_ack_retry #(
	parameter int RETRY_DEPTH = rdar_pkg::DEF_RETRY_DEPTH,
	parameter int SEEN_DEPTH  = rdar_pkg::DEF_SEEN_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [31:0] msg_id,
	input  logic [7:0]  payload_handle,
	input  logic [15:0] elapsed,
	// result
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [31:0] out_id,
	output logic [7:0]  out_handle,
	output logic        last,
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rdar_pkg::*;

	// table index and count widths
	localparam int IW = (RETRY_DEPTH > 1) ? $clog2(RETRY_DEPTH) : 1;
	localparam int CW = $clog2(RETRY_DEPTH + 1);
	// wider width for index arithmetic against the count
	localparam int AW = CW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(RETRY_DEPTH);

	// sequencer and latched command word
	state_t       state_q, state_d;
	logic [2:0]   action_q;
	logic [31:0]  id_q;
	logic [7:0]   handle_q;
	logic [15:0]  elapsed_q;

	// engine state
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [31:0]   next_id_q, next_id_d;
	logic [16:0]   timer_q, timer_d;
	logic          link_q, link_d;
	logic [15:0]   interval_q;

	// retry table memory
	pend_entry_t   pend_mem [RETRY_DEPTH];
	pend_entry_t   prd_q;
	pend_entry_t   pend_wdata;
	logic          pwe;
	logic [IW-1:0] pwaddr;
	logic [IW-1:0] praddr;

	// result word
	logic          emit;
	logic [2:0]    e_kind;
	logic [31:0]   e_id;
	logic [7:0]    e_handle;
	logic          e_last;
	logic          strobe_q;
	logic [2:0]    kind_q;
	logic [31:0]   out_id_q;
	logic [7:0]    out_handle_q;
	logic          last_q;

	// duplicate store handshake
	seen_req_t     seen_req;
	seen_rsp_t     seen_rsp;

	// helpers
	logic          accept;
	logic [AW-1:0] cnt_a;
	logic [AW-1:0] idx_p1;
	logic [AW-1:0] idx_p2;
	logic [16:0]   tsum;
	logic          cfg_wr;
	logic          link_after;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign cnt_a  = AW'(count_q);
	assign idx_p1 = AW'(idx_q) + AW'(1);
	assign idx_p2 = AW'(idx_q) + AW'(2);
	assign tsum   = timer_q + 17'(elapsed_q);

	// a fresh disconnect drops the link before the ack decision
	assign link_after = (action_q == ACT_DISC && !seen_rsp.hit) ? 1'b0 : link_q;

	// in a shift the read runs one entry ahead of the write
	assign praddr = (state_d == ST_SHIFT) ? idx_d + IW'(1) : idx_d;

	rdar_seen #(
		.SEEN_DEPTH(SEEN_DEPTH)
	) u_seen (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (seen_req),
		.id    (id_q),
		.rsp   (seen_rsp)
	);

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
	assign prdata = (paddr == 2'd0) ? {16'd0, interval_q} : 32'd0;

	// sequencer next state and datapath control
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		idx_d         = idx_q;
		next_id_d     = next_id_q;
		timer_d       = timer_q;
		link_d        = link_q;
		pwe           = 1'b0;
		pwaddr        = idx_q;
		pend_wdata    = prd_q;
		emit          = 1'b0;
		e_kind        = KIND_TX;
		e_id          = 32'd0;
		e_handle      = 8'd0;
		e_last        = 1'b0;
		seen_req      = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (action_q)
					ACT_SEND: begin
						if (link_q) begin
							emit     = 1'b1;
							e_last   = 1'b1;
							e_handle = handle_q;
							if (count_q >= DEPTH_C) begin
								e_kind = KIND_FULL;
							end else begin
								e_kind            = KIND_TX;
								e_id              = next_id_q;
								pwe               = 1'b1;
								pwaddr            = IW'(count_q);
								pend_wdata.id     = next_id_q;
								pend_wdata.handle = handle_q;
								count_d           = count_q + CW'(1);
								next_id_d         = (next_id_q == '1) ? FIRST_ID
								                                      : next_id_q + 32'd1;
							end
						end
					end
					ACT_ACK: begin
						if (count_q != '0) begin
							idx_d   = '0;
							state_d = ST_ACK_SCAN;
						end
					end
					ACT_RECV, ACT_DISC: begin
						seen_req.lookup = 1'b1;
						state_d         = ST_SEEN;
					end
					ACT_TICK: begin
						if (tsum > {1'b0, interval_q}) begin
							timer_d = '0;
							if (link_q && count_q != '0) begin
								idx_d   = '0;
								state_d = ST_RETX;
							end
						end else begin
							timer_d = tsum;
						end
					end
					ACT_LINK: begin
						link_d = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_ACK_SCAN: begin
				if (prd_q.id == id_q) begin
					if (idx_p1 >= cnt_a) begin
						count_d = count_q - CW'(1);
						state_d = ST_IDLE;
					end else begin
						state_d = ST_SHIFT;
					end
				end else if (idx_p1 >= cnt_a) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_SHIFT: begin
				// prd_q holds the entry just above idx_q
				pwe        = 1'b1;
				pwaddr     = idx_q;
				pend_wdata = prd_q;
				if (idx_p2 >= cnt_a) begin
					count_d = count_q - CW'(1);
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_RETX: begin
				emit     = 1'b1;
				e_kind   = KIND_RETX;
				e_id     = prd_q.id;
				e_handle = prd_q.handle;
				e_last   = (idx_p1 >= cnt_a);
				if (idx_p1 >= cnt_a) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_SEEN: begin
				if (seen_rsp.done) begin
					if (!seen_rsp.hit) begin
						if (action_q == ACT_DISC) begin
							count_d = '0;
							link_d  = 1'b0;
						end
						seen_req.record = 1'b1;
						emit            = 1'b1;
						e_kind          = KIND_DELIVER;
						e_id            = id_q;
						e_last          = !link_after;
						state_d         = link_after ? ST_ACK_EMIT : ST_IDLE;
					end else begin
						emit    = link_q;
						e_kind  = KIND_ACK;
						e_id    = id_q;
						e_last  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_ACK_EMIT: begin
				emit    = 1'b1;
				e_kind  = KIND_ACK;
				e_id    = id_q;
				e_last  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// retry table: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (pwe) begin
			pend_mem[pwaddr] <= pend_wdata;
		end
		prd_q <= pend_mem[praddr];
	end

	// command word latch, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= action;
			id_q      <= msg_id;
			handle_q  <= payload_handle;
			elapsed_q <= elapsed;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q       <= e_kind;
			out_id_q     <= e_id;
			out_handle_q <= e_handle;
			last_q       <= e_last;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			next_id_q  <= FIRST_ID;
			timer_q    <= '0;
			link_q     <= 1'b0;
			strobe_q   <= 1'b0;
			interval_q <= RETRY_INTERVAL_RST;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			idx_q     <= idx_d;
			next_id_q <= next_id_d;
			timer_q   <= timer_d;
			link_q    <= link_d;
			strobe_q  <= emit;
			if (cfg_wr) begin
				interval_q <= pwdata[15:0];
			end
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign out_id     = out_id_q;
	assign out_handle = out_handle_q;
	assign last       = last_q;

	// a non-final word always comes while the sequencer is still working,
	// and the final word finds it back at rest
	a_last_vs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last != busy))
		else $error("last flag disagrees with sequencer activity");

	// a table-full word only when the table really is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_FULL) |-> (count_q == DEPTH_C))
		else $error("table full reported with free slots");

	// the duplicate store answers only a lookup in progress
	a_seen_done: assert property (@(posedge clk) disable iff (!arst_n)
		seen_rsp.done |-> (state_q == ST_SEEN))
		else $error("duplicate store answered outside a lookup");

	// the id counter never lands on id zero
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_TX) |-> (out_id != 32'd0 && next_id_q != 32'd0))
		else $error("id zero issued");

endmodule
